// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("gpio check failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ----- hdl/gpio_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gpio_pkg;

    localparam int PIN_COUNT = 16;

    // Pins that exist; the rest read as zero and ignore writes.
    localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 72;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        REG_MODE  = 4'd0,
        REG_OTYPE = 4'd1,
        REG_SPEED = 4'd2,
        REG_PULL  = 4'd3,
        REG_IDR   = 4'd4,
        REG_ODR   = 4'd5,
        REG_BSRR  = 4'd6,
        REG_LOCK  = 4'd7,
        REG_AFL   = 4'd8,
        REG_AFH   = 4'd9
    } reg_index_t;

    typedef enum logic [1:0] {
        LOCK_IDLE  = 2'd0,
        LOCK_KEY1  = 2'd1,
        LOCK_KEY0  = 2'd2,
        LOCK_ARMED = 2'd3
    } lock_step_t;

    localparam logic [1:0] MODE_OUTPUT    = 2'b01;
    localparam logic [1:0] MODE_ALTERNATE = 2'b10;

    // Widen a pin mask to a 2-bit-per-pin field mask.
    function automatic logic [31:0] spread2(input logic [15:0] pins);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[2*i +: 2] = {2{pins[i]}};
        end
        return r;
    endfunction

    // Widen an 8-pin mask to a 4-bit-per-pin field mask.
    function automatic logic [31:0] spread4(input logic [7:0] pins);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[4*i +: 4] = {4{pins[i]}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gpio_port_register_block.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake             Payload
// s_        s_tvalid / s_tready   s_tuser: action, reg_index; s_tdata: write_data, pin_levels
// m_        m_tvalid / m_tready   m_tdata: read_data, pad_out, pad_drive_enable,
//                                          write_ignored, lock_engaged
//
// One request is taken per cycle unless a stalled result holds it off; its result is
// registered in the result register. The port registers and the lock sequencer update at the
// accepting edge, so the next request sees them at once.
// A stalled result holds; a new request is taken in the same cycle the held
// result leaves. Reset clears every register but the result data, and clears the lock.

module gpio_port_register_block
    import gpio_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] write_data, [47:32] pin_levels
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // [0] action, [4:1] reg_index
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [M_TDATA_W-1:0] m_tdata   // [31:0] read_data, [47:32] pad_out,
                                                // [63:48] pad_drive_enable,
                                                // [64] write_ignored, [65] lock_engaged
);

    logic [31:0] mode_reg,   mode_next;
    logic [15:0] otype_reg,  otype_next;
    logic [31:0] speed_reg,  speed_next;
    logic [31:0] pull_reg,   pull_next;
    logic [15:0] odr_reg,    odr_next;
    logic [15:0] idr_reg,    idr_next;
    logic [31:0] afl_reg,    afl_next;
    logic [31:0] afh_reg,    afh_next;
    logic [15:0] locked_reg, locked_next;
    logic        key_done_reg, key_done_next;
    lock_step_t  step_reg,   step_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic        accept;
    logic        is_write;
    logic [3:0]  idx;
    logic [31:0] wdata;
    logic        key;
    logic [15:0] lock_mask;
    logic        mask_match;
    logic        lock_wr;
    logic        lock_rd;
    logic        key_set;
    logic [15:0] frozen;
    logic [31:0] allow2;
    logic [31:0] allow_afl;
    logic [31:0] allow_afh;
    logic [31:0] rd;
    logic        ign;
    logic [15:0] drive;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_write   = (s_tuser[0] == ACT_WRITE);
    assign idx        = s_tuser[4:1];
    assign wdata      = s_tdata[31:0];
    assign key        = wdata[16];
    assign lock_mask  = wdata[15:0] & PIN_MASK;
    assign mask_match = (lock_mask == locked_reg);
    assign lock_wr    = accept && is_write && (idx == REG_LOCK) && !key_done_reg;
    assign lock_rd    = accept && !is_write && (idx == REG_LOCK) && !key_done_reg;

    assign frozen    = key_done_reg ? locked_reg : '0;
    assign allow2    = spread2(PIN_MASK & ~frozen);
    assign allow_afl = spread4(PIN_MASK[7:0] & ~frozen[7:0]);
    assign allow_afh = spread4(PIN_MASK[15:8] & ~frozen[15:8]);

    // Lock sequencer: next step.
    always_comb begin
        step_next = step_reg;
        if (lock_wr) begin
            if (step_reg == LOCK_KEY1 && !key && mask_match) begin
                step_next = LOCK_KEY0;
            end else if (step_reg == LOCK_KEY0 && key && mask_match) begin
                step_next = LOCK_ARMED;
            end else begin
                step_next = key ? LOCK_KEY1 : LOCK_IDLE;
            end
        end else if (lock_rd) begin
            step_next = LOCK_IDLE;
        end
    end

    // Lock sequencer: engage on the read that closes the sequence.
    always_comb begin
        key_set = 1'b0;
        unique case (step_reg)
            LOCK_ARMED: key_set = lock_rd;
            default:    key_set = 1'b0;
        endcase
    end

    always_comb begin
        mode_next     = mode_reg;
        otype_next    = otype_reg;
        speed_next    = speed_reg;
        pull_next     = pull_reg;
        odr_next      = odr_reg;
        idr_next      = idr_reg;
        afl_next      = afl_reg;
        afh_next      = afh_reg;
        locked_next   = locked_reg;
        key_done_next = key_done_reg || key_set;
        rd            = '0;
        ign           = 1'b0;

        if (accept) begin
            idr_next = s_tdata[47:32] & PIN_MASK;
            if (!is_write) begin
                unique case (idx)
                    REG_MODE:  rd = mode_reg;
                    REG_OTYPE: rd = {16'd0, otype_reg};
                    REG_SPEED: rd = speed_reg;
                    REG_PULL:  rd = pull_reg;
                    REG_IDR:   rd = {16'd0, idr_next};
                    REG_ODR:   rd = {16'd0, odr_reg};
                    REG_LOCK:  rd = {15'd0, key_done_reg, locked_reg};
                    REG_AFL:   rd = afl_reg;
                    REG_AFH:   rd = afh_reg;
                    default:   rd = '0;
                endcase
            end else begin
                unique case (idx)
                    REG_MODE: begin
                        mode_next = (mode_reg & ~allow2) | (wdata & allow2);
                        ign       = |frozen;
                    end
                    REG_OTYPE: begin
                        otype_next = (otype_reg & ~(PIN_MASK & ~frozen))
                                   | (wdata[15:0] & PIN_MASK & ~frozen);
                        ign        = |frozen;
                    end
                    REG_SPEED: begin
                        speed_next = (speed_reg & ~allow2) | (wdata & allow2);
                        ign        = |frozen;
                    end
                    REG_PULL: begin
                        pull_next = (pull_reg & ~allow2) | (wdata & allow2);
                        ign       = |frozen;
                    end
                    REG_ODR: odr_next = wdata[15:0] & PIN_MASK;
                    // Set wins: clear first, then set.
                    REG_BSRR: odr_next = (odr_reg & ~(wdata[31:16] & PIN_MASK))
                                       | (wdata[15:0] & PIN_MASK);
                    REG_LOCK: begin
                        if (key_done_reg) begin
                            ign = 1'b1;
                        end else if (!((step_reg == LOCK_KEY1 && !key && mask_match) ||
                                       (step_reg == LOCK_KEY0 && key && mask_match))) begin
                            locked_next = lock_mask;
                        end
                    end
                    REG_AFL: begin
                        afl_next = (afl_reg & ~allow_afl) | (wdata & allow_afl);
                        ign      = |frozen[7:0];
                    end
                    REG_AFH: begin
                        afh_next = (afh_reg & ~allow_afh) | (wdata & allow_afh);
                        ign      = |frozen[15:8];
                    end
                    default: ign = 1'b1;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            drive[i] = PIN_MASK[i] && (mode_next[2*i +: 2] == MODE_OUTPUT ||
                                       mode_next[2*i +: 2] == MODE_ALTERNATE);
        end
    end

    assign m_data_next = {6'd0, key_done_next, ign, drive, odr_next, rd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= '0;
            otype_reg    <= '0;
            speed_reg    <= '0;
            pull_reg     <= '0;
            odr_reg      <= '0;
            idr_reg      <= '0;
            afl_reg      <= '0;
            afh_reg      <= '0;
            locked_reg   <= '0;
            key_done_reg <= 1'b0;
            step_reg     <= LOCK_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            otype_reg    <= otype_next;
            speed_reg    <= speed_next;
            pull_reg     <= pull_next;
            odr_reg      <= odr_next;
            idr_reg      <= idr_next;
            afl_reg      <= afl_next;
            afh_reg      <= afh_next;
            locked_reg   <= locked_next;
            key_done_reg <= key_done_next;
            step_reg     <= step_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gpio_port_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gpio_port_checker
    import gpio_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_action,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic seen_lock_reg;
    logic accept;
    logic is_write;

    assign accept   = s_tvalid && s_tready;
    assign is_write = (s_action == ACT_WRITE);

    // Track whether a delivered result has shown the lock engaged.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_lock_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[65]) begin
            seen_lock_reg <= 1'b1;
        end
    end

    `ASSERT_NEXT(a_held_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `ASSERT_NEXT(a_result_follows, aclk, aresetn, accept, m_tvalid)
    `ASSERT_NEXT(a_write_reads_zero, aclk, aresetn, accept && is_write, m_tdata[31:0] == 32'd0)
    `ASSERT_IMPLIES(a_lock_sticky, aclk, aresetn, seen_lock_reg && m_tvalid, m_tdata[65])

endmodule

bind gpio_port_register_block gpio_port_checker u_gpio_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_action (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
